[design/dblom_pkg.sv]
package dblom_pkg;

	localparam int BOOK_DEPTH_DEF  = 16;
	localparam int NUM_SYMBOLS_DEF = 64;
	localparam int MAX_FILLS       = 16;

	localparam int SYM_W   = 6;
	localparam int LVL_W   = 4;
	localparam int WORD_W  = 32;

	// slave tdata field offsets
	localparam int IN_SYM_LO   = 0;
	localparam int IN_LVL_LO   = IN_SYM_LO + SYM_W;
	localparam int IN_SIDE_BIT = IN_LVL_LO + LVL_W;
	localparam int IN_LIMIT_LO = IN_SIDE_BIT + 1;
	localparam int IN_OQTY_LO  = IN_LIMIT_LO + WORD_W;
	localparam int IN_BPX_LO   = IN_OQTY_LO + WORD_W;
	localparam int IN_BQTY_LO  = IN_BPX_LO + WORD_W;
	localparam int IN_APX_LO   = IN_BQTY_LO + WORD_W;
	localparam int IN_AQTY_LO  = IN_APX_LO + WORD_W;
	localparam int IN_USED_W   = IN_AQTY_LO + WORD_W;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	localparam int OUT_USED_W  = SYM_W + 1 + WORD_W + WORD_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// one book entry: {ask qty, ask price, bid qty, bid price}
	localparam int ENTRY_W = 4 * WORD_W;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_MATCH  = 1'b1;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic take;
		logic walk_step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic start_walk;
		logic lvl_fill;
		logic lvl_final;
		logic pend_valid;
		logic out_free;
	} status_t;

endpackage

[design/dblom_ram.sv]
module dblom_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/dblom_ctrl.sv]
module dblom_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  dblom_pkg::status_t status,
	output dblom_pkg::cmd_t    cmd
);

	dblom_pkg::state_t state_q;
	dblom_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dblom_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd.clr_step  = 1'b0;
		cmd.take      = 1'b0;
		cmd.walk_step = 1'b0;
		cmd.flush     = 1'b0;
		case (state_q)
			dblom_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = dblom_pkg::ST_IDLE;
				end
			end
			dblom_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid && status.start_walk) begin
					state_d = dblom_pkg::ST_WALK;
				end
			end
			dblom_pkg::ST_WALK: begin
				if (!status.pend_valid || status.out_free) begin
					cmd.walk_step = 1'b1;
					if (!status.lvl_fill) begin
						state_d = status.pend_valid ? dblom_pkg::ST_FLUSH
						                            : dblom_pkg::ST_IDLE;
					end else if (status.lvl_final) begin
						state_d = dblom_pkg::ST_FLUSH;
					end
				end
			end
			dblom_pkg::ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = dblom_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dblom_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

[design/dblom_datapath.sv]
module dblom_datapath #(
	parameter int BOOK_DEPTH  = dblom_pkg::BOOK_DEPTH_DEF,
	parameter int NUM_SYMBOLS = dblom_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dblom_pkg::cmd_t                    cmd,
	output dblom_pkg::status_t                 status,
	input  logic [dblom_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dblom_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tlast
);

	localparam int BOOK_SIZE   = NUM_SYMBOLS * BOOK_DEPTH;
	localparam int ADDR_W      = BOOK_SIZE > 1 ? $clog2(BOOK_SIZE) : 1;
	localparam int SADDR_W     = NUM_SYMBOLS > 1 ? $clog2(NUM_SYMBOLS) : 1;
	localparam int WALK_LEVELS = BOOK_DEPTH < dblom_pkg::MAX_FILLS ? BOOK_DEPTH
	                                                               : dblom_pkg::MAX_FILLS;
	localparam int IDX_W       = WALK_LEVELS > 1 ? $clog2(WALK_LEVELS) : 1;
	localparam int W           = dblom_pkg::WORD_W;

	logic [dblom_pkg::SYM_W-1:0] in_sym;
	logic [dblom_pkg::LVL_W-1:0] in_lvl;
	logic                        in_side;
	logic [W-1:0]                in_limit;
	logic [W-1:0]                in_oqty;
	logic [dblom_pkg::ENTRY_W-1:0] in_entry;
	logic                        sym_ok;
	logic                        lvl_ok;
	logic                        do_update;
	logic                        do_match;
	logic [W-1:0]                base_full;
	logic [ADDR_W-1:0]           in_base;
	logic [ADDR_W-1:0]           in_addr;

	logic [ADDR_W-1:0]           clr_q;
	logic                        clr_sym;

	logic [ADDR_W-1:0]           base_q;
	logic [dblom_pkg::SYM_W-1:0] sym_q;
	logic                        side_q;
	logic [W-1:0]                limit_q;
	logic [W-1:0]                remain_q;
	logic [IDX_W-1:0]            idx_q;

	logic                        book_we;
	logic [ADDR_W-1:0]           book_waddr;
	logic [dblom_pkg::ENTRY_W-1:0] book_wdata;
	logic                        book_re;
	logic [ADDR_W-1:0]           book_raddr;
	logic [dblom_pkg::ENTRY_W-1:0] book_rdata;
	logic                        ld_we;
	logic [SADDR_W-1:0]          ld_waddr;
	logic                        ld_re;
	logic                        ld_rdata;

	logic [W-1:0]                lv_price;
	logic [W-1:0]                lv_qty;
	logic                        crosses;
	logic                        covers;
	logic                        lvl_fill;
	logic                        lvl_final;
	logic [W-1:0]                fill_qty;
	logic                        step_fill;
	logic                        load_out;

	logic                        pend_valid_q;
	logic [W-1:0]                pend_qty_q;
	logic [W-1:0]                pend_price_q;
	logic                        out_valid_q;
	logic [W-1:0]                out_qty_q;
	logic [W-1:0]                out_price_q;
	logic [dblom_pkg::SYM_W-1:0] out_sym_q;
	logic                        out_side_q;
	logic                        out_last_q;
	logic                        out_free;

	assign in_sym   = s_tdata[dblom_pkg::IN_SYM_LO +: dblom_pkg::SYM_W];
	assign in_lvl   = s_tdata[dblom_pkg::IN_LVL_LO +: dblom_pkg::LVL_W];
	assign in_side  = s_tdata[dblom_pkg::IN_SIDE_BIT];
	assign in_limit = s_tdata[dblom_pkg::IN_LIMIT_LO +: W];
	assign in_oqty  = s_tdata[dblom_pkg::IN_OQTY_LO +: W];
	assign in_entry = s_tdata[dblom_pkg::IN_BPX_LO +: dblom_pkg::ENTRY_W];

	assign sym_ok    = W'(in_sym) < W'(NUM_SYMBOLS);
	assign lvl_ok    = W'(in_lvl) < W'(BOOK_DEPTH);
	assign do_update = cmd.take && s_tuser == dblom_pkg::REQ_UPDATE && sym_ok && lvl_ok;
	assign do_match  = cmd.take && s_tuser == dblom_pkg::REQ_MATCH && sym_ok;
	assign base_full = W'(in_sym) * W'(BOOK_DEPTH);
	assign in_base   = ADDR_W'(base_full);
	assign in_addr   = ADDR_W'(base_full + W'(in_lvl));

	// power-on sweep of the book and the loaded flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign clr_sym = W'(clr_q) < W'(NUM_SYMBOLS);

	assign book_we    = cmd.clr_step || do_update;
	assign book_waddr = cmd.clr_step ? clr_q : in_addr;
	assign book_wdata = cmd.clr_step ? '0 : in_entry;
	assign ld_we      = (cmd.clr_step && clr_sym) || do_update;
	assign ld_waddr   = cmd.clr_step ? SADDR_W'(clr_q) : SADDR_W'(in_sym);
	assign ld_re      = do_match;

	assign book_re    = do_match || (step_fill && !lvl_final);
	assign book_raddr = cmd.take ? in_base : base_q + ADDR_W'(idx_q) + 1'b1;

	dblom_ram #(
		.WIDTH(dblom_pkg::ENTRY_W),
		.DEPTH(BOOK_SIZE)
	) u_book (
		.clk    (clk),
		.wr_en  (book_we),
		.wr_addr(book_waddr),
		.wr_data(book_wdata),
		.rd_en  (book_re),
		.rd_addr(book_raddr),
		.rd_data(book_rdata)
	);

	dblom_ram #(
		.WIDTH(1),
		.DEPTH(NUM_SYMBOLS)
	) u_loaded (
		.clk    (clk),
		.wr_en  (ld_we),
		.wr_addr(ld_waddr),
		.wr_data(!cmd.clr_step),
		.rd_en  (ld_re),
		.rd_addr(SADDR_W'(in_sym)),
		.rd_data(ld_rdata)
	);

	// level evaluation on the registered read data
	always_comb begin
		if (side_q == dblom_pkg::SIDE_SELL) begin
			lv_price = book_rdata[0 +: W];
			lv_qty   = book_rdata[W +: W];
			crosses  = lv_price >= limit_q;
		end else begin
			lv_price = book_rdata[2*W +: W];
			lv_qty   = book_rdata[3*W +: W];
			crosses  = lv_price <= limit_q;
		end
	end

	assign covers    = lv_qty >= remain_q;
	assign lvl_fill  = ld_rdata && remain_q != '0 && crosses;
	assign lvl_final = covers || idx_q == IDX_W'(WALK_LEVELS - 1);
	assign fill_qty  = covers ? remain_q : lv_qty;
	assign step_fill = cmd.walk_step && lvl_fill;
	assign load_out  = (step_fill && pend_valid_q) || cmd.flush;
	assign out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (do_match) begin
			base_q   <= in_base;
			sym_q    <= in_sym;
			side_q   <= in_side;
			limit_q  <= in_limit;
			remain_q <= in_oqty;
		end else if (step_fill) begin
			remain_q <= remain_q - lv_qty;
		end
		if (step_fill) begin
			pend_qty_q   <= fill_qty;
			pend_price_q <= lv_price;
		end
		if (load_out) begin
			out_qty_q   <= pend_qty_q;
			out_price_q <= pend_price_q;
			out_sym_q   <= sym_q;
			out_side_q  <= side_q;
			out_last_q  <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (do_match) begin
				idx_q <= '0;
			end else if (step_fill && !lvl_final) begin
				idx_q <= idx_q + 1'b1;
			end
			if (step_fill) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.clr_last   = clr_q == ADDR_W'(BOOK_SIZE - 1);
	assign status.start_walk = s_tuser == dblom_pkg::REQ_MATCH && sym_ok;
	assign status.lvl_fill   = lvl_fill;
	assign status.lvl_final  = lvl_final;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = dblom_pkg::OUT_TDATA_W'({out_price_q, out_qty_q, out_side_q, out_sym_q});

endmodule

[design/depth_book_limit_order_matcher_unit.sv]
// Depth book limit order matcher.
// Slave channel: one beat is an update (tuser = 0) that writes one bid/ask
// level of one symbol, or a match (tuser = 1) that walks the opposite side
// of that symbol's book from level 0 while levels cross the limit price.
// Master channel: one beat per fill; tlast marks the final fill of an order.
// An update does not hold the slave channel. A match holds it while it
// takes the beat, reads the levels in turn through a single book RAM port
// up to the level that ends the walk, and, if a fill is still held back,
// releases that final fill in a flush step. The walk ends at a level whose
// fill covers the order, at the last walkable level, or at a level that
// gives no fill; a match with no fills does not flush.
// A fill waits in a pending register and moves to the output register when
// the next fill is found or when the walk is flushed. The next item is taken
// while the last fill still waits.
// After reset tready stays low while every book entry and every loaded flag
// is swept to zero.
// When the receiver stalls, the walk pauses with one fill pending behind the
// output register; nothing is dropped.
module depth_book_limit_order_matcher_unit #(
	parameter int BOOK_DEPTH  = dblom_pkg::BOOK_DEPTH_DEF,
	parameter int NUM_SYMBOLS = dblom_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// symbol_index, level_index, side, limit_price, order_quantity,
	// bid_px, bid_qty, ask_px, ask_qty, zero pad
	input  logic [dblom_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// fill_symbol, fill_side, fill_quantity, fill_price, zero pad
	output logic [dblom_pkg::OUT_TDATA_W-1:0] m_tdata,
	// last_fill
	output logic                              m_tlast
);

	dblom_pkg::cmd_t    cmd;
	dblom_pkg::status_t status;

	dblom_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	dblom_datapath #(
		.BOOK_DEPTH (BOOK_DEPTH),
		.NUM_SYMBOLS(NUM_SYMBOLS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[test/book_fill_monitor.sv]
`timescale 1ns / 100ps

module book_fill_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// symbol_index, level_index, side, limit_price, order_quantity,
	// bid_px, bid_qty, ask_px, ask_qty, zero pad
	input  logic [dblom_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// fill_symbol, fill_side, fill_quantity, fill_price, zero pad
	input  logic [dblom_pkg::OUT_TDATA_W-1:0] m_tdata,
	// last_fill
	input  logic                              m_tlast,
	output int                                mismatches,
	output int                                fills_due
);

	localparam int OUT_SYM_LO   = 0;
	localparam int OUT_SIDE_BIT = OUT_SYM_LO + dblom_pkg::SYM_W;
	localparam int OUT_QTY_LO   = OUT_SIDE_BIT + 1;
	localparam int OUT_PX_LO    = OUT_QTY_LO + dblom_pkg::WORD_W;

	typedef logic [dblom_pkg::SYM_W-1:0]       sym_t;
	typedef logic [dblom_pkg::LVL_W-1:0]       lvl_t;
	typedef logic [dblom_pkg::WORD_W-1:0]      word_t;
	typedef logic [dblom_pkg::IN_TDATA_W-1:0]  in_data_t;
	typedef logic [dblom_pkg::OUT_TDATA_W-1:0] out_data_t;

	typedef struct packed {
		sym_t  sym;
		logic  side;
		word_t qty;
		word_t price;
		logic  last;
	} fill_t;

	word_t bid_px  [dblom_pkg::NUM_SYMBOLS_DEF][dblom_pkg::BOOK_DEPTH_DEF];
	word_t bid_qty [dblom_pkg::NUM_SYMBOLS_DEF][dblom_pkg::BOOK_DEPTH_DEF];
	word_t ask_px  [dblom_pkg::NUM_SYMBOLS_DEF][dblom_pkg::BOOK_DEPTH_DEF];
	word_t ask_qty [dblom_pkg::NUM_SYMBOLS_DEF][dblom_pkg::BOOK_DEPTH_DEF];
	logic  loaded  [dblom_pkg::NUM_SYMBOLS_DEF];
	fill_t expected_fills[$];

	initial begin
		for (int s = 0; s < dblom_pkg::NUM_SYMBOLS_DEF; s++) begin
			loaded[sym_t'(s)] = 1'b0;
			for (int l = 0; l < dblom_pkg::BOOK_DEPTH_DEF; l++) begin
				bid_px[sym_t'(s)][lvl_t'(l)]  = '0;
				bid_qty[sym_t'(s)][lvl_t'(l)] = '0;
				ask_px[sym_t'(s)][lvl_t'(l)]  = '0;
				ask_qty[sym_t'(s)][lvl_t'(l)] = '0;
			end
		end
		mismatches = 0;
		fills_due  = 0;
	end

	// book update or order walk; fills of a walk are queued in order
	task automatic apply_order(input in_data_t d, input logic req);
		sym_t  sym;
		lvl_t  lvl;
		logic  side;
		word_t limit;
		word_t remain;
		word_t px;
		word_t lq;
		fill_t held;
		logic  have_held;
		logic  walking;
		int    lv;
		int    n;
		sym    = d[dblom_pkg::IN_SYM_LO +: dblom_pkg::SYM_W];
		lvl    = d[dblom_pkg::IN_LVL_LO +: dblom_pkg::LVL_W];
		side   = d[dblom_pkg::IN_SIDE_BIT];
		limit  = d[dblom_pkg::IN_LIMIT_LO +: dblom_pkg::WORD_W];
		remain = d[dblom_pkg::IN_OQTY_LO +: dblom_pkg::WORD_W];
		if (req == dblom_pkg::REQ_UPDATE) begin
			bid_px[sym][lvl]  = d[dblom_pkg::IN_BPX_LO +: dblom_pkg::WORD_W];
			bid_qty[sym][lvl] = d[dblom_pkg::IN_BQTY_LO +: dblom_pkg::WORD_W];
			ask_px[sym][lvl]  = d[dblom_pkg::IN_APX_LO +: dblom_pkg::WORD_W];
			ask_qty[sym][lvl] = d[dblom_pkg::IN_AQTY_LO +: dblom_pkg::WORD_W];
			loaded[sym]       = 1'b1;
		end else if (loaded[sym]) begin
			held      = '0;
			have_held = 1'b0;
			walking   = (remain != 0);
			lv        = 0;
			n         = 0;
			while (walking && lv < dblom_pkg::BOOK_DEPTH_DEF && n < dblom_pkg::MAX_FILLS) begin
				if (side == dblom_pkg::SIDE_BUY) begin
					px      = ask_px[sym][lvl_t'(lv)];
					lq      = ask_qty[sym][lvl_t'(lv)];
					walking = (px <= limit);
				end else begin
					px      = bid_px[sym][lvl_t'(lv)];
					lq      = bid_qty[sym][lvl_t'(lv)];
					walking = (px >= limit);
				end
				if (walking) begin
					if (have_held)
						expected_fills.push_back(held);
					held.sym   = sym;
					held.side  = side;
					held.price = px;
					held.qty   = (lq >= remain) ? remain : lq;
					held.last  = 1'b0;
					have_held  = 1'b1;
					n++;
					if (lq >= remain)
						walking = 1'b0;
					else
						remain = remain - lq;
				end
				lv++;
			end
			if (have_held) begin
				held.last = 1'b1;
				expected_fills.push_back(held);
			end
		end
	endtask

	task automatic check_fill(input out_data_t d, input logic last);
		fill_t want;
		if (expected_fills.size() == 0) begin
			$error("fill beat with no fill expected: tdata %h tlast %b", d, last);
			mismatches++;
		end else begin
			want = expected_fills.pop_front();
			if (d[OUT_SYM_LO +: dblom_pkg::SYM_W] !== want.sym) begin
				$error("fill_symbol: expected %0d, got %0d", want.sym,
					d[OUT_SYM_LO +: dblom_pkg::SYM_W]);
				mismatches++;
			end
			if (d[OUT_SIDE_BIT] !== want.side) begin
				$error("fill_side: expected %0d, got %0d", want.side, d[OUT_SIDE_BIT]);
				mismatches++;
			end
			if (d[OUT_QTY_LO +: dblom_pkg::WORD_W] !== want.qty) begin
				$error("fill_quantity: expected %0d, got %0d", want.qty,
					d[OUT_QTY_LO +: dblom_pkg::WORD_W]);
				mismatches++;
			end
			if (d[OUT_PX_LO +: dblom_pkg::WORD_W] !== want.price) begin
				$error("fill_price: expected %0d, got %0d", want.price,
					d[OUT_PX_LO +: dblom_pkg::WORD_W]);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_fill: expected %0d, got %0d", want.last, last);
				mismatches++;
			end
		end
	endtask

	// output beat first: a beat taken now cannot stem from an order taken now
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_fill(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				apply_order(s_tdata, s_tuser);
			fills_due = expected_fills.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	typedef logic [dblom_pkg::SYM_W-1:0]       sym_t;
	typedef logic [dblom_pkg::LVL_W-1:0]       lvl_t;
	typedef logic [dblom_pkg::WORD_W-1:0]      word_t;
	typedef logic [dblom_pkg::IN_TDATA_W-1:0]  in_data_t;
	typedef logic [dblom_pkg::OUT_TDATA_W-1:0] out_data_t;

	typedef struct packed {
		logic  req;
		sym_t  sym;
		lvl_t  lvl;
		logic  side;
		word_t limit;
		word_t qty;
		word_t bpx;
		word_t bqty;
		word_t apx;
		word_t aqty;
	} book_req_t;

	logic      clk      = 1'b0;
	logic      arst_n   = 1'b0;
	logic      s_tvalid = 1'b0;
	logic      s_tuser  = 1'b0;
	in_data_t  s_tdata  = '0;
	logic      m_tready = 1'b0;
	logic      s_tready;
	logic      m_tvalid;
	out_data_t m_tdata;
	logic      m_tlast;
	int        mismatches;
	int        fills_due;

	int burst_left = 0;
	int items      = 0;
	bit hold_due   = 1'b0;

	always #5 clk = ~clk;

	depth_book_limit_order_matcher_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	book_fill_monitor watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.fills_due  (fills_due)
	);

	function automatic in_data_t to_tdata(book_req_t r);
		in_data_t d;
		d = '0;
		d[dblom_pkg::IN_SYM_LO +: dblom_pkg::SYM_W]    = r.sym;
		d[dblom_pkg::IN_LVL_LO +: dblom_pkg::LVL_W]    = r.lvl;
		d[dblom_pkg::IN_SIDE_BIT]                      = r.side;
		d[dblom_pkg::IN_LIMIT_LO +: dblom_pkg::WORD_W] = r.limit;
		d[dblom_pkg::IN_OQTY_LO +: dblom_pkg::WORD_W]  = r.qty;
		d[dblom_pkg::IN_BPX_LO +: dblom_pkg::WORD_W]   = r.bpx;
		d[dblom_pkg::IN_BQTY_LO +: dblom_pkg::WORD_W]  = r.bqty;
		d[dblom_pkg::IN_APX_LO +: dblom_pkg::WORD_W]   = r.apx;
		d[dblom_pkg::IN_AQTY_LO +: dblom_pkg::WORD_W]  = r.aqty;
		return d;
	endfunction

	// unused fields carry random filler
	function automatic book_req_t upd(sym_t sym, lvl_t lvl, word_t bpx, word_t bqty,
			word_t apx, word_t aqty);
		book_req_t r;
		r.req   = dblom_pkg::REQ_UPDATE;
		r.sym   = sym;
		r.lvl   = lvl;
		r.side  = 1'($urandom_range(0, 1));
		r.limit = $urandom;
		r.qty   = $urandom;
		r.bpx   = bpx;
		r.bqty  = bqty;
		r.apx   = apx;
		r.aqty  = aqty;
		return r;
	endfunction

	function automatic book_req_t mat(sym_t sym, logic side, word_t limit, word_t qty);
		book_req_t r;
		r.req   = dblom_pkg::REQ_MATCH;
		r.sym   = sym;
		r.lvl   = lvl_t'($urandom_range(0, 15));
		r.side  = side;
		r.limit = limit;
		r.qty   = qty;
		r.bpx   = $urandom;
		r.bqty  = $urandom;
		r.apx   = $urandom;
		r.aqty  = $urandom;
		return r;
	endfunction

	function automatic book_req_t noise_req();
		book_req_t r;
		r.req   = 1'($urandom_range(0, 1));
		r.sym   = sym_t'($urandom_range(0, 63));
		r.lvl   = lvl_t'($urandom_range(0, 15));
		r.side  = 1'($urandom_range(0, 1));
		r.limit = $urandom;
		r.qty   = $urandom;
		r.bpx   = $urandom;
		r.bqty  = $urandom;
		r.apx   = $urandom;
		r.aqty  = $urandom;
		return r;
	endfunction

	function automatic sym_t hot_symbol();
		return sym_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
		                                          : $urandom_range(0, 7));
	endfunction

	function automatic word_t level_lots();
		if ($urandom_range(0, 4) == 0)
			return '0;
		else if ($urandom_range(0, 9) == 0)
			return $urandom;
		else
			return $urandom_range(1, 200);
	endfunction

	function automatic word_t order_lots();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return $urandom;
		else
			return $urandom_range(1, 1500);
	endfunction

	// sender: bursts of random length, random gaps between them
	task automatic offer(book_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.req;
		s_tdata  <= to_tdata(r);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
		items++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (fills_due != 0)
			@(negedge clk);
		burst_left = 0;
	endtask

	// fresh levels from level 0 of one symbol's book, then orders that walk into them
	task automatic book_episode();
		sym_t  sym;
		word_t mid;
		word_t acc_b;
		word_t acc_a;
		word_t limit;
		logic  side;
		int    depth;
		int    spread;
		sym   = hot_symbol();
		depth = $urandom_range(1, dblom_pkg::BOOK_DEPTH_DEF);
		mid   = $urandom_range(100000, 32'hF000_0000);
		acc_b = '0;
		acc_a = '0;
		for (int lv = 0; lv < depth; lv++) begin
			acc_b = acc_b + $urandom_range(0, 40);
			acc_a = acc_a + $urandom_range(0, 40);
			offer(upd(sym, lvl_t'(lv), mid - 1 - acc_b, level_lots(), mid + 1 + acc_a,
				level_lots()));
		end
		repeat ($urandom_range(1, 5)) begin
			side   = 1'($urandom_range(0, 1));
			spread = $urandom_range(0, 800);
			if (side == dblom_pkg::SIDE_BUY)
				limit = mid + word_t'(spread) - 200;
			else
				limit = mid - word_t'(spread) + 200;
			if ($urandom_range(0, 15) == 0)
				limit = (side == dblom_pkg::SIDE_BUY) ? '1 : '0;
			offer(mat(sym, side, limit, order_lots()));
		end
	endtask

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: stall pattern of its own, one long hold-off
	initial begin : receiver
		int mode;
		int len;
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_due && !hold_done) begin
				hold_done = 1'b1;
				repeat (400) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(8, 80);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int kind;
		int next_drain;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		offer(mat(sym_t'(5), dblom_pkg::SIDE_BUY, '1, 100));
		offer(upd(sym_t'(0), lvl_t'(0), 100, 10, 110, 20));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_BUY, 110, 5));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_BUY, 109, 5));
		// zero levels behind the best one cross and give zero fills up to the cap
		offer(mat(sym_t'(0), dblom_pkg::SIDE_BUY, '1, 50));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_SELL, '0, '1));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_SELL, 100, 0));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_SELL, 101, 5));
		offer(upd(sym_t'(63), lvl_t'(15), '1, '1, '1, '1));
		offer(mat(sym_t'(63), dblom_pkg::SIDE_SELL, 1, 9));
		offer(mat(sym_t'(63), dblom_pkg::SIDE_BUY, 0, 7));
		offer(mat(sym_t'(63), dblom_pkg::SIDE_BUY, '1, '1));
		offer(mat(sym_t'(63), dblom_pkg::SIDE_SELL, '0, 1));
		offer(upd(sym_t'(0), lvl_t'(1), 90, 30, 120, 15));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_BUY, 120, 35));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_SELL, 90, 40));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_SELL, 95, 40));
		offer(upd(sym_t'(0), lvl_t'(0), 0, 0, 0, 0));
		offer(mat(sym_t'(0), dblom_pkg::SIDE_BUY, 0, 3));
		offer(mat(sym_t'(1), dblom_pkg::SIDE_SELL, 0, 1));
		drain();

		items      = 0;
		next_drain = 120;
		while (items < 500) begin
			if (items >= 60)
				hold_due = 1'b1;
			if (items >= next_drain) begin
				drain();
				next_drain += 120;
			end
			kind = $urandom_range(0, 9);
			if (kind < 6)
				book_episode();
			else if (kind < 8)
				offer(noise_req());
			else if (kind == 8)
				offer(mat(hot_symbol(), 1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? '1 : '0, order_lots()));
			else
				offer(upd(hot_symbol(), lvl_t'($urandom_range(0, 15)), $urandom, $urandom,
					$urandom, $urandom));
		end
		drain();
		repeat (40) @(negedge clk);

		if (mismatches == 0 && fills_due == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
